// ===== sv/rwb_pkg.sv =====
// shared types, register codes and constants of the rotated window blit address generator
package rwb_pkg;

    localparam int MAX_DIM   = 2048;
    localparam int DIM_W     = 12;
    localparam int WIN_W     = 13;
    localparam int SPAN_W    = 14;
    localparam int COORD_W   = 16;
    localparam int COLOR_W   = 16;
    localparam int ADDR_W    = 22;
    localparam int ROT_W     = 2;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_FB_WIDTH   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FB_HEIGHT  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROTATION   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WIN_LEFT   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WIN_TOP    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd6;

    localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
    localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
    localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
    localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

    localparam logic [DIM_W-1:0] FB_WIDTH_RST  = 12'd1024;
    localparam logic [DIM_W-1:0] FB_HEIGHT_RST = 12'd600;

    // live configuration, with derived sizes
    typedef struct packed {
        logic [DIM_W-1:0]         fw;
        logic [DIM_W-1:0]         fh;
        logic [ROT_W-1:0]         rot;
        logic signed [WIN_W-1:0]  wl;
        logic signed [WIN_W-1:0]  wt;
        logic signed [SPAN_W-1:0] ww;
        logic signed [SPAN_W-1:0] wh;
    } t_cfg;

    // logical position of one pixel
    typedef struct packed {
        logic [COLOR_W-1:0]        color;
        logic signed [COORD_W-1:0] lx;
        logic signed [COORD_W-1:0] ly;
        logic                      empty;
        logic                      done;
    } t_pos_item;

    // physical position after rotation and clipping
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [DIM_W-1:0]   px;
        logic [DIM_W-1:0]   py;
        logic               we;
        logic               done;
    } t_map_item;

endpackage

// ===== sv/rwb_cfg.sv =====
// configuration register file behind the apb-style port
module rwb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwb_pkg::PADDR_W-1:0]   paddr,
    input  logic [rwb_pkg::PDATA_W-1:0]   pwdata,
    output logic [rwb_pkg::PDATA_W-1:0]   prdata,
    output logic                          o_win_wr,
    output rwb_pkg::t_cfg                 o_cfg
);

    logic [rwb_pkg::DIM_W-1:0]   r_fb_width;
    logic [rwb_pkg::DIM_W-1:0]   r_fb_height;
    logic [rwb_pkg::ROT_W-1:0]   r_rotation;
    logic [rwb_pkg::WIN_W-1:0]   r_win_left;
    logic [rwb_pkg::WIN_W-1:0]   r_win_top;
    logic [rwb_pkg::WIN_W-1:0]   r_win_right;
    logic [rwb_pkg::WIN_W-1:0]   r_win_bottom;
    logic                        wr_en;
    logic [rwb_pkg::REG_IDX_W-1:0] idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[rwb_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_width   <= rwb_pkg::FB_WIDTH_RST;
            r_fb_height  <= rwb_pkg::FB_HEIGHT_RST;
            r_rotation   <= rwb_pkg::ROT_0;
            r_win_left   <= '0;
            r_win_top    <= '0;
            r_win_right  <= '0;
            r_win_bottom <= '0;
        end else if (wr_en) begin
            unique case (idx)
                rwb_pkg::REG_FB_WIDTH:   r_fb_width   <= pwdata[rwb_pkg::DIM_W-1:0];
                rwb_pkg::REG_FB_HEIGHT:  r_fb_height  <= pwdata[rwb_pkg::DIM_W-1:0];
                rwb_pkg::REG_ROTATION:   r_rotation   <= pwdata[rwb_pkg::ROT_W-1:0];
                rwb_pkg::REG_WIN_LEFT:   r_win_left   <= pwdata[rwb_pkg::WIN_W-1:0];
                rwb_pkg::REG_WIN_TOP:    r_win_top    <= pwdata[rwb_pkg::WIN_W-1:0];
                rwb_pkg::REG_WIN_RIGHT:  r_win_right  <= pwdata[rwb_pkg::WIN_W-1:0];
                rwb_pkg::REG_WIN_BOTTOM: r_win_bottom <= pwdata[rwb_pkg::WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rwb_pkg::REG_FB_WIDTH:   prdata = rwb_pkg::PDATA_W'(r_fb_width);
            rwb_pkg::REG_FB_HEIGHT:  prdata = rwb_pkg::PDATA_W'(r_fb_height);
            rwb_pkg::REG_ROTATION:   prdata = rwb_pkg::PDATA_W'(r_rotation);
            rwb_pkg::REG_WIN_LEFT:   prdata = rwb_pkg::PDATA_W'(r_win_left);
            rwb_pkg::REG_WIN_TOP:    prdata = rwb_pkg::PDATA_W'(r_win_top);
            rwb_pkg::REG_WIN_RIGHT:  prdata = rwb_pkg::PDATA_W'(r_win_right);
            rwb_pkg::REG_WIN_BOTTOM: prdata = rwb_pkg::PDATA_W'(r_win_bottom);
            default:                 prdata = '0;
        endcase
    end

    // any window register write restarts the scan
    assign o_win_wr = wr_en && ((idx == rwb_pkg::REG_WIN_LEFT) ||
                                (idx == rwb_pkg::REG_WIN_TOP) ||
                                (idx == rwb_pkg::REG_WIN_RIGHT) ||
                                (idx == rwb_pkg::REG_WIN_BOTTOM));

    // saturate sizes, derive window span
    always_comb begin
        o_cfg.fw  = ({1'b0, r_fb_width} > (rwb_pkg::DIM_W+1)'(rwb_pkg::MAX_DIM)) ?
                    rwb_pkg::DIM_W'(rwb_pkg::MAX_DIM) : r_fb_width;
        o_cfg.fh  = ({1'b0, r_fb_height} > (rwb_pkg::DIM_W+1)'(rwb_pkg::MAX_DIM)) ?
                    rwb_pkg::DIM_W'(rwb_pkg::MAX_DIM) : r_fb_height;
        o_cfg.rot = r_rotation;
        o_cfg.wl  = $signed(r_win_left);
        o_cfg.wt  = $signed(r_win_top);
        o_cfg.ww  = $signed({r_win_right[rwb_pkg::WIN_W-1], r_win_right}) -
                    $signed({r_win_left[rwb_pkg::WIN_W-1], r_win_left});
        o_cfg.wh  = $signed({r_win_bottom[rwb_pkg::WIN_W-1], r_win_bottom}) -
                    $signed({r_win_top[rwb_pkg::WIN_W-1], r_win_top});
    end

endmodule

// ===== sv/rwb_pos.sv =====
// column and row counters and the input register
module rwb_pos (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rwb_pkg::t_cfg               i_cfg,
    input  logic                        i_win_wr,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [rwb_pkg::COLOR_W-1:0] i_color,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rwb_pkg::t_pos_item          o_item
);

    logic [rwb_pkg::WIN_W-1:0] r_col;
    logic [rwb_pkg::WIN_W-1:0] r_row;
    logic [rwb_pkg::WIN_W-1:0] n_col;
    logic [rwb_pkg::WIN_W-1:0] n_row;
    logic                      r_valid;
    rwb_pkg::t_pos_item        r_item;
    rwb_pkg::t_pos_item        n_item;
    logic                      accept;
    logic                      empty;
    logic                      col_last;
    logic                      row_last;

    assign o_stall = r_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    assign empty    = (i_cfg.ww <= 0) || (i_cfg.wh <= 0);
    assign col_last = $signed({1'b0, r_col}) >= (i_cfg.ww - rwb_pkg::SPAN_W'(1));
    assign row_last = $signed({1'b0, r_row}) >= (i_cfg.wh - rwb_pkg::SPAN_W'(1));

    always_comb begin
        n_item.color = i_color;
        n_item.lx    = rwb_pkg::COORD_W'(i_cfg.wl) + rwb_pkg::COORD_W'({1'b0, r_col});
        n_item.ly    = rwb_pkg::COORD_W'(i_cfg.wt) + rwb_pkg::COORD_W'({1'b0, r_row});
        n_item.empty = empty;
        n_item.done  = 1'b0;
        n_col        = r_col + 1'b1;
        n_row        = r_row;
        if (empty) begin
            n_col       = '0;
            n_row       = '0;
            n_item.done = 1'b1;
        end else if (col_last) begin
            n_col = '0;
            if (row_last) begin
                n_row       = '0;
                n_item.done = 1'b1;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_win_wr) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (!o_stall) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/rwb_map.sv =====
// rotation onto the framebuffer and clipping
module rwb_map (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rwb_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    output logic               o_stall,
    input  rwb_pkg::t_pos_item i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output rwb_pkg::t_map_item o_item
);

    logic signed [rwb_pkg::COORD_W-1:0] fw_s;
    logic signed [rwb_pkg::COORD_W-1:0] fh_s;
    logic signed [rwb_pkg::COORD_W-1:0] fw_m1;
    logic signed [rwb_pkg::COORD_W-1:0] fh_m1;
    logic signed [rwb_pkg::COORD_W-1:0] px;
    logic signed [rwb_pkg::COORD_W-1:0] py;
    logic                               inside_fb;
    logic                               r_valid;
    rwb_pkg::t_map_item                 r_item;
    rwb_pkg::t_map_item                 n_item;
    logic                               load;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    assign fw_s  = $signed(rwb_pkg::COORD_W'(i_cfg.fw));
    assign fh_s  = $signed(rwb_pkg::COORD_W'(i_cfg.fh));
    assign fw_m1 = fw_s - rwb_pkg::COORD_W'(1);
    assign fh_m1 = fh_s - rwb_pkg::COORD_W'(1);

    always_comb begin
        case (i_cfg.rot)
            rwb_pkg::ROT_90: begin
                px = fw_m1 - i_item.ly;
                py = i_item.lx;
            end
            rwb_pkg::ROT_180: begin
                px = fw_m1 - i_item.lx;
                py = fh_m1 - i_item.ly;
            end
            rwb_pkg::ROT_270: begin
                px = i_item.ly;
                py = fh_m1 - i_item.lx;
            end
            default: begin
                px = i_item.lx;
                py = i_item.ly;
            end
        endcase
    end

    assign inside_fb = (px >= 0) && (py >= 0) && (px < fw_s) && (py < fh_s);

    // clipped pixels carry a zero position so the address comes out zero
    always_comb begin
        n_item.color = i_item.color;
        n_item.we    = inside_fb && !i_item.empty;
        n_item.px    = n_item.we ? px[rwb_pkg::DIM_W-1:0] : '0;
        n_item.py    = n_item.we ? py[rwb_pkg::DIM_W-1:0] : '0;
        n_item.done  = i_item.done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== sv/rwb_addr.sv =====
// pixel index multiply-add and result register
module rwb_addr (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [rwb_pkg::DIM_W-1:0]   i_fw,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  rwb_pkg::t_map_item          i_item,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [rwb_pkg::ADDR_W-1:0]  o_address,
    output logic [rwb_pkg::COLOR_W-1:0] o_color,
    output logic                        o_enable,
    output logic                        o_done
);

    localparam int PROD_W = 2 * rwb_pkg::DIM_W;

    logic [PROD_W-1:0]           prod;
    logic [PROD_W:0]             sum;
    logic                        r_valid;
    logic [rwb_pkg::ADDR_W-1:0]  r_address;
    logic [rwb_pkg::COLOR_W-1:0] r_color;
    logic                        r_enable;
    logic                        r_done;
    logic                        load;

    assign o_stall = r_valid && i_stall;
    assign load    = i_valid && !o_stall;

    assign prod = i_item.py * i_fw;
    assign sum  = {1'b0, prod} + (PROD_W+1)'(i_item.px);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_address <= sum[rwb_pkg::ADDR_W-1:0];
            r_color   <= i_item.color;
            r_enable  <= i_item.we;
            r_done    <= i_item.done;
        end
    end

    assign o_valid   = r_valid;
    assign o_address = r_address;
    assign o_color   = r_color;
    assign o_enable  = r_enable;
    assign o_done    = r_done;

endmodule

// ===== sv/rotated_window_blit_address_gen_unit.sv =====
// top level of the rotated window blit address generator
//
//  channel   direction  handshake                    payload
//  pixel in  in         i_in_valid / o_in_stall      i_pixel_color
//  write out out        o_out_valid / i_out_stall    o_write_address, o_write_color,
//                                                    o_write_enable, o_window_done
//  config    in         psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  one item per clock sustained while the output is not stalled; three register stages
//  (input register, rotate and clip, multiply-add), so an accepted item passes through
//  the input register and the rotate and clip register into the result register
//  the row-times-width multiply in the last stage sets the longest path
//  reset is synchronous and active low: all three stages empty, counters at zero,
//  registers at their reset values
//  a stalled output holds its result; stall passes back combinationally through full stages
//  only, so the input keeps taking items while any stage downstream has a free slot
module rotated_window_blit_address_gen_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // pixel input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rwb_pkg::COLOR_W-1:0]   i_pixel_color,
    // framebuffer write channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rwb_pkg::ADDR_W-1:0]    o_write_address,
    output logic [rwb_pkg::COLOR_W-1:0]   o_write_color,
    output logic                          o_write_enable,
    output logic                          o_window_done,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rwb_pkg::PADDR_W-1:0]   paddr,
    input  logic [rwb_pkg::PDATA_W-1:0]   pwdata,
    output logic [rwb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    rwb_pkg::t_cfg      cfg;
    logic               win_wr;
    logic               pos_valid;
    logic               pos_stall;
    rwb_pkg::t_pos_item pos_item;
    logic               map_valid;
    logic               map_stall;
    rwb_pkg::t_map_item map_item;

    // no wait states on the register port
    assign pready = 1'b1;

    // register file; sizes come out saturated, window span precomputed
    rwb_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .o_win_wr (win_wr),
        .o_cfg    (cfg)
    );

    // scan position: counters advance on each accepted item of a non-empty window
    // unless a window write clears them; the logical coordinate is latched with the colour
    rwb_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_win_wr (win_wr),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_color  (i_pixel_color),
        .o_valid  (pos_valid),
        .i_stall  (pos_stall),
        .o_item   (pos_item)
    );

    // rotation and clipping against the framebuffer bounds
    rwb_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_valid  (pos_valid),
        .o_stall  (pos_stall),
        .i_item   (pos_item),
        .o_valid  (map_valid),
        .i_stall  (map_stall),
        .o_item   (map_item)
    );

    // row times width plus column, into the result register
    rwb_addr u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fw      (cfg.fw),
        .i_valid   (map_valid),
        .o_stall   (map_stall),
        .i_item    (map_item),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_address (o_write_address),
        .o_color   (o_write_color),
        .o_enable  (o_write_enable),
        .o_done    (o_window_done)
    );

endmodule

// ===== tb/tb_rwb_write_checker.sv =====
`timescale 1ns / 1ps
// checker that predicts every framebuffer write from the pixel items and compares it
module tb_rwb_write_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [rwb_pkg::COLOR_W-1:0]   i_pixel_color,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [rwb_pkg::ADDR_W-1:0]    i_write_address,
    input  logic [rwb_pkg::COLOR_W-1:0]   i_write_color,
    input  logic                          i_write_enable,
    input  logic                          i_window_done,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [rwb_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [rwb_pkg::PDATA_W-1:0]   i_pwdata,
    output int                            o_mismatches,
    output int                            o_pending
);
    import rwb_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               done;
    } t_fb_write;

    t_fb_write expected_writes[$];

    // shadow of the register file and the window position
    logic [DIM_W-1:0] fb_w;
    logic [DIM_W-1:0] fb_h;
    logic [ROT_W-1:0] rot;
    logic [WIN_W-1:0] win_l;
    logic [WIN_W-1:0] win_t;
    logic [WIN_W-1:0] win_r;
    logic [WIN_W-1:0] win_b;
    logic [WIN_W-1:0] col_cnt;
    logic [WIN_W-1:0] row_cnt;
    int               errors = 0;

    assign o_mismatches = errors;

    task automatic apply_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] word);
        logic restart;
        restart = 1'b0;
        case (idx)
            REG_FB_WIDTH:   fb_w = word[DIM_W-1:0];
            REG_FB_HEIGHT:  fb_h = word[DIM_W-1:0];
            REG_ROTATION:   rot  = word[ROT_W-1:0];
            REG_WIN_LEFT:   begin win_l = word[WIN_W-1:0]; restart = 1'b1; end
            REG_WIN_TOP:    begin win_t = word[WIN_W-1:0]; restart = 1'b1; end
            REG_WIN_RIGHT:  begin win_r = word[WIN_W-1:0]; restart = 1'b1; end
            REG_WIN_BOTTOM: begin win_b = word[WIN_W-1:0]; restart = 1'b1; end
            default: ;
        endcase
        // any window edge moves the walk back to the first pixel
        if (restart) begin
            col_cnt = '0;
            row_cnt = '0;
        end
    endtask

    task automatic predict_write(input logic [COLOR_W-1:0] colour, output t_fb_write wr);
        int left, top, cols, rows, fw, fh, lx, ly, px, py, flat;
        left = $signed(win_l);
        top  = $signed(win_t);
        cols = $signed(win_r) - left;
        rows = $signed(win_b) - top;
        fw   = (fb_w > MAX_DIM) ? MAX_DIM : fb_w;
        fh   = (fb_h > MAX_DIM) ? MAX_DIM : fb_h;
        wr.addr  = '0;
        wr.color = colour;
        wr.we    = 1'b0;
        wr.done  = 1'b0;
        if (cols <= 0 || rows <= 0) begin
            // empty window: nothing lands, every item closes it
            col_cnt = '0;
            row_cnt = '0;
            wr.done = 1'b1;
        end else begin
            lx = left + int'(col_cnt);
            ly = top + int'(row_cnt);
            case (rot)
                ROT_90:  begin px = fw - 1 - ly; py = lx;          end
                ROT_180: begin px = fw - 1 - lx; py = fh - 1 - ly; end
                ROT_270: begin px = ly;          py = fh - 1 - lx; end
                default: begin px = lx;          py = ly;          end
            endcase
            if (px >= 0 && py >= 0 && px < fw && py < fh) begin
                flat    = py * fw + px;
                wr.we   = 1'b1;
                wr.addr = flat[ADDR_W-1:0];
            end
            if (int'(col_cnt) >= cols - 1) begin
                col_cnt = '0;
                if (int'(row_cnt) >= rows - 1) begin
                    row_cnt = '0;
                    wr.done = 1'b1;
                end else begin
                    row_cnt = row_cnt + 1'b1;
                end
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: write %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_fb_write wr;
        t_fb_write want;
        if (!i_rst_n) begin
            fb_w    = FB_WIDTH_RST;
            fb_h    = FB_HEIGHT_RST;
            rot     = ROT_0;
            win_l   = '0;
            win_t   = '0;
            win_r   = '0;
            win_b   = '0;
            col_cnt = '0;
            row_cnt = '0;
            expected_writes.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                apply_reg(i_paddr[PADDR_W-1:2], i_pwdata);
            // outputs first: a write leaving now never belongs to a pixel entering now
            if (i_out_valid && !i_out_stall) begin
                if (expected_writes.size() == 0) begin
                    errors++;
                    $display("%0t ns: write with none expected, expected nothing, got %s",
                             $time, $sformatf("addr 0x%0h colour 0x%0h we %0b done %0b",
                             i_write_address, i_write_color, i_write_enable,
                             i_window_done));
                end else begin
                    want = expected_writes.pop_front();
                    check_field("address", 32'(want.addr), 32'(i_write_address));
                    check_field("colour", 32'(want.color), 32'(i_write_color));
                    check_field("enable", 32'(want.we), 32'(i_write_enable));
                    check_field("window done", 32'(want.done), 32'(i_window_done));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_write(i_pixel_color, wr);
                expected_writes.push_back(wr);
            end
        end
        o_pending <= expected_writes.size();
    end

endmodule

// ===== tb/tb_rotated_window_blit_address_gen_unit.sv =====
`timescale 1ns / 1ps
// stimulus, back-pressure and verdict for the rotated window blit address generator
module tb_rotated_window_blit_address_gen_unit;
    import rwb_pkg::*;

    localparam int RANDOM_ITEMS  = 1150;
    // longest quiet stretch allowed: long input gaps, long stalls and a burst of
    // register writes all stay far below this
    localparam int IDLE_LIMIT    = 2000;
    // three pipeline stages plus slack, watched for stray writes at the end
    localparam int SETTLE_CYCLES = 8;
    // unmapped register slot, writes there must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [COLOR_W-1:0]   i_pixel_color;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [ADDR_W-1:0]    o_write_address;
    logic [COLOR_W-1:0]   o_write_color;
    logic                 o_write_enable;
    logic                 o_window_done;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int   mismatches;
    int   pending;
    int   idle_cycles = 0;
    // no input gaps while set, to keep the pipeline full
    logic burst = 1'b0;
    // window edges as last written, used to size each run of pixels
    int   cur_left   = 0;
    int   cur_top    = 0;
    int   cur_right  = 0;
    int   cur_bottom = 0;

    // 10 ns clock, low half first so the first rising edge is at 5 ns
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    rotated_window_blit_address_gen_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_pixel_color   (i_pixel_color),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_write_address (o_write_address),
        .o_write_color   (o_write_color),
        .o_write_enable  (o_write_enable),
        .o_window_done   (o_window_done),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    tb_rwb_write_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_pixel_color   (i_pixel_color),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_write_address (o_write_address),
        .i_write_color   (o_write_color),
        .i_write_enable  (o_write_enable),
        .i_window_done   (o_window_done),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_pready        (pready),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    // watchdog: any item in, any write out or any register access counts as progress
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output back-pressure: mostly short stalls, now and then a long one, and now and
    // then a long stall-free stretch so the pipeline also runs flat out
    initial begin : write_backpressure
        int free_run;
        int hold;
        i_out_stall <= 1'b0;
        forever begin
            if ($urandom_range(4) == 0)
                free_run = $urandom_range(200, 40);
            else
                free_run = $urandom_range(4, 1);
            repeat (free_run) @(posedge i_clk);
            if ($urandom_range(9) == 0)
                hold = $urandom_range(40, 8);
            else
                hold = $urandom_range(3, 1);
            i_out_stall <= 1'b1;
            repeat (hold) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // gap before a pixel: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 88) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // framebuffer size: mostly tiny, sometimes zero, medium, near or beyond the maximum
    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(19);
        if (roll == 0) return 0;
        if (roll < 12) return $urandom_range(8, 1);
        if (roll < 15) return $urandom_range(64, 9);
        if (roll < 17) return $urandom_range(MAX_DIM, MAX_DIM - 8);
        return $urandom_range(4095, MAX_DIM + 1);
    endfunction

    // window start along one axis of a framebuffer of the given size
    function automatic int pick_start(input int span);
        int roll;
        roll = $urandom_range(3);
        if (span > 16 && roll == 0) return span - int'($urandom_range(10));
        if (span > 16 && roll == 1) return $urandom_range(span - 1);
        return int'($urandom_range(span + 5)) - 3;
    endfunction

    // one pixel item, held until the block takes it; valid stays high afterwards
    task automatic send_pixel(input logic [COLOR_W-1:0] colour);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_color <= colour;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic run_pixels(input int count);
        logic [31:0] colour;
        for (int k = 0; k < count; k++) begin
            colour = $urandom();
            send_pixel(colour[COLOR_W-1:0]);
        end
    endtask

    // stop feeding and wait until every predicted write has come out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // register write: setup phase, access phase, then the bus goes idle
    task automatic set_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        logic [PDATA_W-1:0] word;
        logic [PDATA_W-1:0] noise;
        word  = value;
        noise = $urandom();
        // bits above the widest field are don't-care; sometimes fill them with rubbish
        if ($urandom_range(3) == 0)
            word[PDATA_W-1:WIN_W] = noise[PDATA_W-1:WIN_W];
        else
            word[PDATA_W-1:WIN_W] = '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_WIN_LEFT:   cur_left   = value;
            REG_WIN_TOP:    cur_top    = value;
            REG_WIN_RIGHT:  cur_right  = value;
            REG_WIN_BOTTOM: cur_bottom = value;
            default: ;
        endcase
    endtask

    // new setting for one random phase
    task automatic randomise_config();
        int roll, fw, fh, span, cols, rows;
        roll = $urandom_range(9);
        // rotation alone: the walk carries on where it stopped
        if (roll < 2) begin
            set_reg(REG_ROTATION, $urandom_range(3));
            return;
        end
        // only the right edge moves: restarts the walk with a new width
        if (roll == 2) begin
            set_reg(REG_WIN_RIGHT, cur_left + int'($urandom_range(6, 1)));
            return;
        end
        if (roll == 3)
            set_reg(REG_SPARE, $urandom());
        fw = pick_dim();
        fh = pick_dim();
        set_reg(REG_FB_WIDTH, fw);
        set_reg(REG_FB_HEIGHT, fh);
        set_reg(REG_ROTATION, $urandom_range(3));
        fw   = (fw > MAX_DIM) ? MAX_DIM : fw;
        fh   = (fh > MAX_DIM) ? MAX_DIM : fh;
        span = (fw > fh) ? fw : fh;
        cols = $urandom_range(6, 1);
        rows = $urandom_range(5, 1);
        roll = $urandom_range(19);
        if (roll == 0) begin
            // window pinned at the far ends of the signed coordinate range
            cur_left = $urandom_range(1) ? -4096 : 4095 - cols;
            cur_top  = $urandom_range(1) ? -4096 : 4095 - rows;
            set_reg(REG_WIN_LEFT, cur_left);
            set_reg(REG_WIN_TOP, cur_top);
            set_reg(REG_WIN_RIGHT, cur_left + cols);
            set_reg(REG_WIN_BOTTOM, cur_top + rows);
        end else if (roll == 1) begin
            // empty window, on one axis or the other
            cur_left = pick_start(span);
            cur_top  = pick_start(span);
            set_reg(REG_WIN_LEFT, cur_left);
            set_reg(REG_WIN_TOP, cur_top);
            if ($urandom_range(1)) begin
                set_reg(REG_WIN_RIGHT, cur_left - int'($urandom_range(3)));
                set_reg(REG_WIN_BOTTOM, cur_top + rows);
            end else begin
                set_reg(REG_WIN_RIGHT, cur_left + cols);
                set_reg(REG_WIN_BOTTOM, cur_top - int'($urandom_range(3)));
            end
        end else begin
            cur_left = pick_start(span);
            cur_top  = pick_start(span);
            set_reg(REG_WIN_LEFT, cur_left);
            set_reg(REG_WIN_TOP, cur_top);
            set_reg(REG_WIN_RIGHT, cur_left + cols);
            set_reg(REG_WIN_BOTTOM, cur_top + rows);
        end
    endtask

    // pixels for one phase: whole windows plus a partial one where the window is small
    function automatic int phase_length();
        int area;
        area = 0;
        if (cur_right > cur_left && cur_bottom > cur_top)
            area = (cur_right - cur_left) * (cur_bottom - cur_top);
        if (area > 0 && area <= 48)
            return area * int'($urandom_range(3, 1)) + int'($urandom_range(area - 1));
        return $urandom_range(40, 5);
    endfunction

    initial begin : stimulus
        int sent;
        int count;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_pixel_color <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset the window is empty: each item is clipped and closes the window
        send_pixel(16'h0000);
        send_pixel(16'hFFFF);
        send_pixel(16'hA5A5);
        wait_idle();

        // 4x3 framebuffer, 3x2 window hanging off the top left corner
        set_reg(REG_FB_WIDTH, 4);
        set_reg(REG_FB_HEIGHT, 3);
        set_reg(REG_ROTATION, ROT_0);
        set_reg(REG_WIN_LEFT, -1);
        set_reg(REG_WIN_TOP, -1);
        set_reg(REG_WIN_RIGHT, 2);
        set_reg(REG_WIN_BOTTOM, 1);
        run_pixels(6);
        wait_idle();

        // rotation changes mid window leave the walk where it is
        set_reg(REG_ROTATION, ROT_90);
        run_pixels(3);
        wait_idle();
        set_reg(REG_ROTATION, ROT_180);
        run_pixels(3);
        wait_idle();
        set_reg(REG_ROTATION, ROT_270);
        run_pixels(2);
        wait_idle();

        // rewriting an edge mid window restarts at the first pixel
        set_reg(REG_WIN_LEFT, -1);
        run_pixels(2);
        wait_idle();

        // oversized framebuffer saturates; rotated 180 near the far corner
        set_reg(REG_FB_WIDTH, 4095);
        set_reg(REG_FB_HEIGHT, 4095);
        set_reg(REG_ROTATION, ROT_180);
        set_reg(REG_WIN_LEFT, MAX_DIM - 2);
        set_reg(REG_WIN_TOP, MAX_DIM - 2);
        set_reg(REG_WIN_RIGHT, MAX_DIM + 1);
        set_reg(REG_WIN_BOTTOM, MAX_DIM - 1);
        run_pixels(3);
        wait_idle();

        // zero width: nothing lands anywhere
        set_reg(REG_FB_WIDTH, 0);
        run_pixels(2);
        wait_idle();

        // top address of the largest framebuffer, then the most negative column;
        // the spare slot write before the first pixels must change nothing
        set_reg(REG_FB_WIDTH, MAX_DIM);
        set_reg(REG_FB_HEIGHT, MAX_DIM);
        set_reg(REG_ROTATION, ROT_0);
        set_reg(REG_WIN_LEFT, MAX_DIM - 1);
        set_reg(REG_WIN_TOP, MAX_DIM - 1);
        set_reg(REG_WIN_RIGHT, 4095);
        set_reg(REG_WIN_BOTTOM, 4095);
        set_reg(REG_SPARE, 32'h0000_1FFF);
        run_pixels(2);
        wait_idle();
        set_reg(REG_WIN_LEFT, -4096);
        run_pixels(1);
        wait_idle();

        // random phases: fresh setting, then whole windows of random colours
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            randomise_config();
            count = phase_length();
            burst = ($urandom_range(4) == 0);
            run_pixels(count);
            sent += count;
            wait_idle();
        end

        // let any stray write show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rwb_pkg.sv
sv/rwb_cfg.sv
sv/rwb_pos.sv
sv/rwb_map.sv
sv/rwb_addr.sv
sv/rotated_window_blit_address_gen_unit.sv
tb/tb_rwb_write_checker.sv
tb/tb_rotated_window_blit_address_gen_unit.sv
